// ----- rtl/rdc_pkg.sv -----
// shared types, constants and helpers for the roofline dvfs candidate block
package rdc_pkg;

  // field widths
  localparam int unsigned IntensityW = 32;
  localparam int unsigned TokenW     = 21;
  localparam int unsigned FreqW      = 22;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned EnvW       = 29;
  localparam int unsigned ScaleW     = 15;
  localparam int unsigned NumCand    = 6;

  // grid frequencies in khz
  localparam logic [FreqW-1:0] CpuMinKhz = 22'd600000;
  localparam logic [FreqW-1:0] CpuM1Khz  = 22'd1400000;
  localparam logic [FreqW-1:0] CpuM2Khz  = 22'd2200000;
  localparam logic [FreqW-1:0] CpuMaxKhz = 22'd3000000;
  localparam logic [FreqW-1:0] MemMinKhz = 22'd575000;
  localparam logic [FreqW-1:0] MemM1Khz  = 22'd1300000;
  localparam logic [FreqW-1:0] MemM2Khz  = 22'd1700000;
  localparam logic [FreqW-1:0] MemMaxKhz = 22'd2020000;

  // environment factor limits in q.28 and unity long scale in q1.14
  localparam logic [EnvW-1:0]   EnvLo   = 29'h0800_0000;
  localparam logic [EnvW-1:0]   EnvHi   = 29'h1000_0000;
  localparam logic [ScaleW-1:0] LsOne   = 15'd16384;

  // register reset values
  localparam logic [31:0] KneeRst   = 32'd65536;
  localparam logic [15:0] LowMRst   = 16'd4096;
  localparam logic [15:0] HighMRst  = 16'd8192;
  localparam logic [19:0] LongThRst = 20'd1048575;
  localparam logic [23:0] RatioRst  = 24'd65536;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KNEE      = 3'd0,
    CFG_LOW_M     = 3'd1,
    CFG_HIGH_M    = 3'd2,
    CFG_LONG_TH   = 3'd3,
    CFG_LONG_SC   = 3'd4,
    CFG_RATIO     = 3'd5,
    CFG_THERMAL   = 3'd6,
    CFG_BATTERY   = 3'd7
  } cfg_idx_e;

  // frame classes
  typedef enum logic [1:0] {
    CLS_MEM  = 2'd0,
    CLS_MIX  = 2'd1,
    CLS_COMP = 2'd2
  } cls_e;

  typedef struct packed {
    logic [31:0]       knee;
    logic [15:0]       mem_bound_mgn;
    logic [15:0]       comp_bound_mgn;
    logic [19:0]       long_threshold;
    logic [ScaleW-1:0] long_scale;
    logic [23:0]       ratio;
    logic [ScaleW-1:0] thermal;
    logic [ScaleW-1:0] battery;
  } cfg_t;

  // classified frame leaving the front end
  typedef struct packed {
    cls_e              cls;
    logic [EnvW-1:0]   env;
    logic [ScaleW-1:0] ls;
  } front_t;

  // entries 0..2 cpu, 3..5 memory
  typedef logic [NumCand-1:0][FreqW-1:0] freq6_t;

  typedef struct packed {
    freq6_t             freq;
    logic [NumCand-1:0] keep;
  } cand_t;

  // grid frequencies for a frame class
  function automatic freq6_t base_freqs(cls_e cls);
    freq6_t f;
    f = '0;
    unique case (cls)
      CLS_MEM: begin
        f[0] = CpuMinKhz; f[1] = CpuM1Khz;  f[2] = CpuM2Khz;
        f[3] = MemM1Khz;  f[4] = MemM2Khz;  f[5] = MemMaxKhz;
      end
      CLS_MIX: begin
        f[0] = CpuM1Khz;  f[1] = CpuM2Khz;  f[2] = CpuMaxKhz;
        f[3] = MemM1Khz;  f[4] = MemM2Khz;  f[5] = MemMaxKhz;
      end
      default: begin
        f[0] = CpuM1Khz;  f[1] = CpuM2Khz;  f[2] = CpuMaxKhz;
        f[3] = MemMinKhz; f[4] = MemM1Khz;  f[5] = MemM2Khz;
      end
    endcase
    return f;
  endfunction

  // clamp a rounded value into a domain range
  function automatic logic [FreqW-1:0] sat_range(logic [24:0] v, logic [FreqW-1:0] lo,
                                                 logic [FreqW-1:0] hi);
    logic [FreqW-1:0] r;
    if (v < 25'(lo)) begin
      r = lo;
    end else if (v > 25'(hi)) begin
      r = hi;
    end else begin
      r = v[FreqW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/roofline_dvfs_candidates_top.sv -----
// top level: configuration registers, front end, scaling lanes and output stage
//
// Roofline dvfs candidate generator. Each input item on the s_axis channel is
// one work frame (intensity, token index). The block sorts it as memory-bound,
// mixed or compute-bound and sends two to six candidate items on m_axis: the
// cpu frequencies ascending, then the memory frequencies ascending, repeated
// neighbors dropped; tuser marks the domain and tlast the frame's final item.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while no frame is in flight, as the block does not
// enforce this. A write takes effect at the next edge. A frame passes two
// front stages, three scaling stages and the output register.
// Throughput: one candidate per cycle while m_axis_tready is high; a frame
// holds the output register until its last candidate is taken.
// Frames enter back to back while up to five more are in the pipe.
// Reset clears all valid bits and loads register defaults. When the receiver
// holds tready low the output item stays put and the stages fill up, then
// s_axis_tready drops; nothing is lost or repeated.
module roofline_dvfs_candidates_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [31:0] intensity, [52:32] token_index
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [21:0] freq_khz
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // [0] domain
);

  rdc_pkg::cfg_t   cfg_q;
  rdc_pkg::front_t fr;
  rdc_pkg::cand_t  cand;
  logic            fr_valid, fr_ready, cand_valid, cand_ready;
  logic            domain;
  logic [rdc_pkg::FreqW-1:0] freq_khz;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.knee           <= rdc_pkg::KneeRst;
      cfg_q.mem_bound_mgn  <= rdc_pkg::LowMRst;
      cfg_q.comp_bound_mgn <= rdc_pkg::HighMRst;
      cfg_q.long_threshold <= rdc_pkg::LongThRst;
      cfg_q.long_scale     <= rdc_pkg::LsOne;
      cfg_q.ratio          <= rdc_pkg::RatioRst;
      cfg_q.thermal        <= rdc_pkg::LsOne;
      cfg_q.battery        <= rdc_pkg::LsOne;
    end else if (cfg_we_i) begin
      unique case (rdc_pkg::cfg_idx_e'(cfg_idx_i))
        rdc_pkg::CFG_KNEE:    cfg_q.knee           <= cfg_data_i;
        rdc_pkg::CFG_LOW_M:   cfg_q.mem_bound_mgn  <= cfg_data_i[15:0];
        rdc_pkg::CFG_HIGH_M:  cfg_q.comp_bound_mgn <= cfg_data_i[15:0];
        rdc_pkg::CFG_LONG_TH: cfg_q.long_threshold <= cfg_data_i[19:0];
        rdc_pkg::CFG_LONG_SC: cfg_q.long_scale     <= cfg_data_i[14:0];
        rdc_pkg::CFG_RATIO:   cfg_q.ratio          <= cfg_data_i[23:0];
        rdc_pkg::CFG_THERMAL: cfg_q.thermal        <= cfg_data_i[14:0];
        rdc_pkg::CFG_BATTERY: cfg_q.battery        <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // classification front end
  rdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .intensity_i   (s_axis_tdata[31:0]),
    .token_index_i (s_axis_tdata[52:32]),
    .out_valid_o   (fr_valid),
    .out_ready_i   (fr_ready),
    .out_o         (fr)
  );

  // frequency scaling lanes
  rdc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_i        (fr),
    .out_valid_o (cand_valid),
    .out_ready_i (cand_ready),
    .out_o       (cand)
  );

  // candidate output stage
  rdc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cand_valid),
    .in_ready_o  (cand_ready),
    .in_i        (cand),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .domain_o    (domain),
    .freq_khz_o  (freq_khz),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, freq_khz};
  assign m_axis_tuser = domain;

endmodule

// ----- rtl/rdc_front.sv -----
// front end: intensity and limit products, long scale pick, then class and env clamp
module rdc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rdc_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rdc_pkg::IntensityW-1:0] intensity_i,
  input  logic [rdc_pkg::TokenW-1:0]    token_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rdc_pkg::front_t               out_o
);

  logic        va_q, vb_q, ready_a, ready_b;
  logic [55:0] eff_q, eff_d;
  logic [47:0] lo_q, lo_d, hi_q, hi_d;
  logic [29:0] env_raw_q, env_raw_d;
  logic [rdc_pkg::ScaleW-1:0] ls_q, ls_d;
  logic [31:0] knee_eff;
  logic [55:0] lo_lim, hi_lim;
  rdc_pkg::front_t fr_d, fr_q;

  // stall control
  assign ready_b    = !vb_q || out_ready_i;
  assign ready_a    = !va_q || ready_b;
  assign in_ready_o = ready_a;

  // stage a: products and long scale pick
  assign knee_eff  = (cfg_i.knee == '0) ? 32'd1 : cfg_i.knee;
  assign eff_d     = 56'(intensity_i) * 56'(cfg_i.ratio);
  assign lo_d      = 48'(cfg_i.mem_bound_mgn) * 48'(knee_eff);
  assign hi_d      = 48'(cfg_i.comp_bound_mgn) * 48'(knee_eff);
  assign env_raw_d = 30'(cfg_i.thermal) * 30'(cfg_i.battery);
  assign ls_d      = (!token_index_i[rdc_pkg::TokenW-1] &&
                      (token_index_i[19:0] >= cfg_i.long_threshold)) ?
                     cfg_i.long_scale : rdc_pkg::LsOne;

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      eff_q     <= eff_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      env_raw_q <= env_raw_d;
      ls_q      <= ls_d;
    end
  end

  // stage b: class compare and environment clamp
  assign lo_lim = {4'b0, lo_q, 4'b0};
  assign hi_lim = {4'b0, hi_q, 4'b0};

  always_comb begin
    fr_d    = '0;
    fr_d.ls = ls_q;
    if (eff_q < lo_lim) begin
      fr_d.cls = rdc_pkg::CLS_MEM;
    end else if (eff_q < hi_lim) begin
      fr_d.cls = rdc_pkg::CLS_MIX;
    end else begin
      fr_d.cls = rdc_pkg::CLS_COMP;
    end
    if (env_raw_q < 30'(rdc_pkg::EnvLo)) begin
      fr_d.env = rdc_pkg::EnvLo;
    end else if (env_raw_q > 30'(rdc_pkg::EnvHi)) begin
      fr_d.env = rdc_pkg::EnvHi;
    end else begin
      fr_d.env = env_raw_q[rdc_pkg::EnvW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      fr_q <= fr_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= in_valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  assign out_valid_o = vb_q;
  assign out_o       = fr_q;

endmodule

// ----- rtl/rdc_scale.sv -----
// frequency scaling lanes: env product, long-scale product, rounding, clamp, dedup mask
module rdc_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rdc_pkg::front_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rdc_pkg::cand_t  out_o
);

  logic vc_q, vd_q, ve_q, ready_c, ready_d, ready_e;
  rdc_pkg::freq6_t base;
  logic [2:0][50:0] tc_q, tc_d, tm_q, tm_d;
  logic [rdc_pkg::ScaleW-1:0] ls_q;
  logic [2:0][65:0] pc_q, pc_d;
  logic [2:0][rdc_pkg::FreqW-1:0] mv_q, mv_d, cv;
  logic [2:0][50:0] msum;
  logic [2:0][66:0] csum;
  rdc_pkg::cand_t cand_d, cand_q;

  // stall control
  assign ready_e    = !ve_q || out_ready_i;
  assign ready_d    = !vd_q || ready_e;
  assign ready_c    = !vc_q || ready_d;
  assign in_ready_o = ready_c;

  // stage c: grid frequency times environment factor
  assign base = rdc_pkg::base_freqs(in_i.cls);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tc_d[i] = 51'(base[i]) * 51'(in_i.env);
      tm_d[i] = 51'(base[i+3]) * 51'(in_i.env);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && in_valid_i) begin
      tc_q <= tc_d;
      tm_q <= tm_d;
      ls_q <= in_i.ls;
    end
  end

  // stage d: cpu long-scale product, memory rounding and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc_d[i] = 66'(tc_q[i]) * 66'(ls_q);
      msum[i] = tm_q[i] + (51'(1) << 27);
      mv_d[i] = rdc_pkg::sat_range(25'(msum[i][50:28]), rdc_pkg::MemMinKhz,
                                   rdc_pkg::MemMaxKhz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_d && vc_q) begin
      pc_q <= pc_d;
      mv_q <= mv_d;
    end
  end

  // stage e: cpu rounding and clamp, drop repeated neighbors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = 67'(pc_q[i]) + (67'(1) << 41);
      cv[i]   = rdc_pkg::sat_range(csum[i][66:42], rdc_pkg::CpuMinKhz,
                                   rdc_pkg::CpuMaxKhz);
    end
    cand_d      = '0;
    for (int i = 0; i < 3; i++) begin
      cand_d.freq[i]   = cv[i];
      cand_d.freq[i+3] = mv_q[i];
    end
    cand_d.keep[0] = 1'b1;
    cand_d.keep[1] = (cv[1] != cv[0]);
    cand_d.keep[2] = (cv[2] != cv[1]);
    cand_d.keep[3] = 1'b1;
    cand_d.keep[4] = (mv_q[1] != mv_q[0]);
    cand_d.keep[5] = (mv_q[2] != mv_q[1]);
  end

  always_ff @(posedge clk_i) begin
    if (ready_e && vd_q) begin
      cand_q <= cand_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (ready_c) vc_q <= in_valid_i;
      if (ready_d) vd_q <= vc_q;
      if (ready_e) ve_q <= vd_q;
    end
  end

  assign out_valid_o = ve_q;
  assign out_o       = cand_q;

endmodule

// ----- rtl/rdc_emit.sv -----
// output register: sends the kept candidates of one frame, one item per cycle while out_ready_i is high
module rdc_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rdc_pkg::cand_t               in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         domain_o,
  output logic [rdc_pkg::FreqW-1:0]    freq_khz_o,
  output logic                         last_o
);

  rdc_pkg::freq6_t              vals_q;
  logic [rdc_pkg::NumCand-1:0]  keep_q, keep_d, keep_rest;
  logic [2:0]                   idx;
  logic                         busy, load;

  // lowest pending candidate
  always_comb begin
    idx = 3'd0;
    for (int i = rdc_pkg::NumCand - 1; i >= 0; i--) begin
      if (keep_q[i]) idx = 3'(i);
    end
  end

  assign busy       = |keep_q;
  assign keep_rest  = keep_q & (keep_q - 6'd1);
  assign last_o     = (keep_rest == '0);
  assign in_ready_o = !busy || (out_ready_i && last_o);
  assign load       = in_ready_o && in_valid_i;

  // pending mask update
  always_comb begin
    keep_d = keep_q;
    if (load) begin
      keep_d = in_i.keep;
    end else if (busy && out_ready_i) begin
      keep_d = keep_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= '0;
    end else begin
      keep_q <= keep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vals_q <= in_i.freq;
    end
  end

  assign out_valid_o = busy;
  assign freq_khz_o  = vals_q[idx];
  assign domain_o    = (keep_q[2:0] == 3'b000);

endmodule
